// File: hdl/qslerp_pkg.sv
package qslerp_pkg;

    // Fixed-point layout of the fields
    localparam int FRAC_BITS = 15;
    localparam logic [16:0] Q_ONE = 17'd1 << FRAC_BITS;

    // CORDIC datapath widths: x/y and angle
    localparam int XW = 34;
    localparam int ZW = 33;

    localparam logic [XW-1:0] CORDIC_GAIN_INV = 34'd652032874;
    localparam logic [61:0]   Q60_ONE         = 62'd1 << 60;
    localparam logic [33:0]   Q30_ONE         = 34'd1 << 30;
    localparam logic [34:0]   WEIGHT_LIMIT    = 35'd1 << 34;

    // Component order: 0 = w, 1 = x, 2 = y, 3 = z
    typedef logic [3:0][15:0] t_quat;

    // Per-item data riding alongside the arithmetic cells
    typedef struct packed {
        t_quat       a;
        t_quat       b;
        logic [15:0] t;
        logic        sflip;
        logic        lin;
        logic [30:0] c;
        logic [30:0] s;
    } t_side;

    // Q30 arctangent of 2^-idx
    function automatic logic [29:0] atan_q30(input logic [4:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:    v = 30'd843314857;
            5'd1:    v = 30'd497837829;
            5'd2:    v = 30'd263043837;
            5'd3:    v = 30'd133525159;
            5'd4:    v = 30'd67021687;
            5'd5:    v = 30'd33543516;
            5'd6:    v = 30'd16775851;
            5'd7:    v = 30'd8388437;
            5'd8:    v = 30'd4194283;
            5'd9:    v = 30'd2097149;
            5'd31:   v = 30'd0;
            default: v = 30'd1 << (5'd30 - idx);
        endcase
        return v;
    endfunction

    function automatic logic [15:0] sat16(input logic signed [23:0] v);
        logic [15:0] r;
        if (v > 24'sd32767) begin
            r = 16'h7fff;
        end else if (v < -24'sd32768) begin
            r = 16'h8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

// File: hdl/qslerp_sqrt_cell.sv
// One digit of a restoring integer square root.
module qslerp_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [61:0] i_n,
    input  logic [61:0] i_r,
    output logic [61:0] o_n,
    output logic [61:0] o_r
);
    localparam logic [61:0] BIT = 62'd1 << (60 - 2 * STEP);

    logic [61:0] w_trial;
    logic        w_ge;

    assign w_trial = i_r + BIT;
    assign w_ge    = (i_n >= w_trial);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_n <= w_ge ? (i_n - w_trial) : i_n;
            o_r <= w_ge ? ((i_r >> 1) + BIT) : (i_r >> 1);
        end
    end
endmodule

// File: hdl/qslerp_cordic_cell.sv
// One micro-rotation; vectoring drives y to zero, rotation drives z to zero.
module qslerp_cordic_cell #(
    parameter int STEP   = 0,
    parameter bit VECTOR = 1'b1
) (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [qslerp_pkg::XW-1:0]     i_x,
    input  logic signed [qslerp_pkg::XW-1:0]     i_y,
    input  logic signed [qslerp_pkg::ZW-1:0]     i_z,
    output logic signed [qslerp_pkg::XW-1:0]     o_x,
    output logic signed [qslerp_pkg::XW-1:0]     o_y,
    output logic signed [qslerp_pkg::ZW-1:0]     o_z
);
    localparam logic signed [qslerp_pkg::ZW-1:0] ANG =
        $signed({3'b000, qslerp_pkg::atan_q30(5'(STEP))});

    logic signed [qslerp_pkg::XW-1:0] w_dx;
    logic signed [qslerp_pkg::XW-1:0] w_dy;
    logic                             w_up;

    assign w_dx = i_y >>> STEP;
    assign w_dy = i_x >>> STEP;
    assign w_up = VECTOR ? !i_y[qslerp_pkg::XW-1] : i_z[qslerp_pkg::ZW-1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (w_up) begin
                o_x <= i_x + w_dx;
                o_y <= i_y - w_dy;
                o_z <= i_z + ANG;
            end else begin
                o_x <= i_x - w_dx;
                o_y <= i_y + w_dy;
                o_z <= i_z - ANG;
            end
        end
    end
endmodule

// File: hdl/qslerp_div_cell.sv
// One quotient bit of a restoring divider; the tag rides along.
module qslerp_div_cell (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [30:0] i_den,
    input  logic [30:0] i_rem,
    input  logic [34:0] i_dl,
    input  logic [34:0] i_q,
    input  logic [1:0]  i_tag,
    output logic [30:0] o_rem,
    output logic [34:0] o_dl,
    output logic [34:0] o_q,
    output logic [1:0]  o_tag
);
    logic [31:0] w_nr;
    logic [31:0] w_diff;
    logic        w_ge;

    assign w_nr   = {i_rem, i_dl[34]};
    assign w_ge   = (w_nr >= {1'b0, i_den});
    assign w_diff = w_nr - {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem <= w_ge ? w_diff[30:0] : w_nr[30:0];
            o_dl  <= {i_dl[33:0], 1'b0};
            o_q   <= {i_q[33:0], w_ge};
            o_tag <= i_tag;
        end
    end
endmodule

// File: hdl/quaternion_slerp_core.sv
// Quaternion spherical linear interpolation, Q1.15 in and out.
//
// Input channel (i_in_valid / o_in_ready): quaternions a and b and the blend
// factor; blend above 1.0 is clamped. Output channel (o_out_valid /
// i_out_ready): the interpolated quaternion, rounded and saturated.
// Config channel (i_cfg_valid / o_cfg_ready, always ready): near_threshold;
// write it only while no item is in flight.
//
// The datapath is a chain of cells: dot product, 31 square-root digit cells,
// CORDIC_STEPS vectoring cells for theta, two rows of CORDIC_STEPS rotation
// cells for the two sines, two rows of 35 divider cells for the weights, and
// final multiply and round stages. One item enters every cycle unless the
// chain holds; throughput is one transfer per cycle while the chain runs.
// A two-entry output queue (result register plus skid) decouples the sides:
// when the receiver stalls the queue fills and the whole chain holds, and
// o_in_ready drops in the same cycle. Reset clears all valid bits and the
// queue and sets near_threshold to 33.
module quaternion_slerp_core #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_a_w,
    input  logic [15:0] i_a_x,
    input  logic [15:0] i_a_y,
    input  logic [15:0] i_a_z,
    input  logic [15:0] i_b_w,
    input  logic [15:0] i_b_x,
    input  logic [15:0] i_b_y,
    input  logic [15:0] i_b_z,
    input  logic [15:0] i_blend,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_r_w,
    output logic [15:0] o_r_x,
    output logic [15:0] o_r_y,
    output logic [15:0] o_r_z,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_near_threshold
);
    localparam int XW = qslerp_pkg::XW;
    localparam int ZW = qslerp_pkg::ZW;
    localparam int N  = CORDIC_STEPS;
    localparam int SQRT_N = 31;
    localparam int DIV_N  = 35;

    // Stage positions along the chain
    localparam int P_PROD  = 1;
    localparam int P_DOT   = 2;
    localparam int P_ABS   = 3;
    localparam int P_SQ    = 4;
    localparam int P_RAD   = 5;
    localparam int P_ROOT  = P_RAD + SQRT_N + 1;
    localparam int P_ANGB  = P_ROOT + N + 1;
    localparam int P_ANGA  = P_ANGB + 1;
    localparam int P_DPREP = P_ANGA + N + 1;
    localparam int P_WGT   = P_DPREP + DIV_N + 1;
    localparam int P_MUL   = P_WGT + 1;
    localparam int P_LAST  = P_MUL + 1;

    logic en;

    // Configuration register
    logic [15:0] r_thr;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= 16'd33;
        end else if (i_cfg_valid) begin
            r_thr <= i_cfg_near_threshold;
        end
    end

    // Valid bits and side data along the chain
    logic                  r_vld  [0:P_LAST];
    qslerp_pkg::t_side     r_side [0:P_LAST];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j <= P_LAST; j++) begin
                r_vld[j] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_in_valid;
            for (int j = 1; j <= P_LAST; j++) begin
                r_vld[j] <= r_vld[j-1];
            end
        end
    end

    // Capture the item; clamp blend to 1.0
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0].a     <= {i_a_z, i_a_y, i_a_x, i_a_w};
            r_side[0].b     <= {i_b_z, i_b_y, i_b_x, i_b_w};
            r_side[0].t     <= (i_blend > 16'd32768) ? 16'd32768 : i_blend;
            r_side[0].sflip <= 1'b0;
            r_side[0].lin   <= 1'b0;
            r_side[0].c     <= '0;
            r_side[0].s     <= '0;
        end
    end

    // Dot product
    logic signed [31:0] r_prod [4];
    logic signed [33:0] r_dot;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                r_prod[k] <= $signed(r_side[0].a[k]) * $signed(r_side[0].b[k]);
            end
            r_dot <= 34'(r_prod[0]) + 34'(r_prod[1]) + 34'(r_prod[2]) + 34'(r_prod[3]);
        end
    end

    // Fold negative cosine onto b's weight sign
    logic        w_dneg;
    logic [32:0] w_cabs;
    logic [32:0] r_cabs;
    logic        w_lin0;

    assign w_dneg = r_dot[33];
    assign w_cabs = w_dneg ? 33'(-r_dot) : 33'(r_dot);

    // linear when cos + eps > 1.0
    assign w_lin0 = ({1'b0, r_cabs} + {3'b000, r_thr, 15'd0}) > qslerp_pkg::Q30_ONE;

    logic [61:0] r_csq;
    logic [61:0] r_rad;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cabs <= w_cabs;
            r_csq  <= 62'(r_cabs[30:0]) * 62'(r_cabs[30:0]);
            r_rad  <= qslerp_pkg::Q60_ONE - r_csq;
        end
    end

    // sin(theta) = sqrt(1 - c^2): one root digit per cell
    logic [61:0] w_sn [0:SQRT_N];
    logic [61:0] w_sr [0:SQRT_N];
    assign w_sn[0] = r_rad;
    assign w_sr[0] = '0;

    for (genvar k = 0; k < SQRT_N; k++) begin : g_sqrt
        qslerp_sqrt_cell #(.STEP(k)) u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_n   (w_sn[k]),
            .i_r   (w_sr[k]),
            .o_n   (w_sn[k+1]),
            .o_r   (w_sr[k+1])
        );
    end

    // Side line: hand data down, update flags where they become known
    for (genvar j = 1; j <= P_LAST; j++) begin : g_side
        qslerp_pkg::t_side n_side;
        always_comb begin
            n_side = r_side[j-1];
            if (j == P_ABS) begin
                n_side.sflip = w_dneg;
                n_side.c     = w_cabs[30:0];
            end
            if (j == P_SQ) begin
                n_side.lin = w_lin0;
            end
            if (j == P_ROOT) begin
                n_side.s   = w_sr[SQRT_N][30:0];
                n_side.lin = r_side[j-1].lin | (w_sr[SQRT_N][30:0] == 31'd0);
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_side[j] <= n_side;
            end
        end
    end

    // theta = atan2(sin, cos) by vectoring
    logic signed [XW-1:0] w_vx [0:N];
    logic signed [XW-1:0] w_vy [0:N];
    logic signed [ZW-1:0] w_vz [0:N];
    assign w_vx[0] = $signed(XW'(r_side[P_ROOT].c));
    assign w_vy[0] = $signed(XW'(r_side[P_ROOT].s));
    assign w_vz[0] = '0;

    for (genvar k = 0; k < N; k++) begin : g_vec
        qslerp_cordic_cell #(.STEP(k), .VECTOR(1'b1)) u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_x   (w_vx[k]),
            .i_y   (w_vy[k]),
            .i_z   (w_vz[k]),
            .o_x   (w_vx[k+1]),
            .o_y   (w_vy[k+1]),
            .o_z   (w_vz[k+1])
        );
    end

    // Split theta: b gets floor(t * theta), a the rest
    logic signed [49:0]   w_tprod;
    logic signed [ZW-1:0] r_theta;
    logic signed [ZW-1:0] r_angb;
    logic signed [ZW-1:0] r_anga2;
    logic signed [ZW-1:0] r_angb2;

    assign w_tprod = $signed({1'b0, r_side[P_ANGB-1].t}) * w_vz[N];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_theta <= w_vz[N];
            r_angb  <= w_tprod[47:15];
            r_anga2 <= r_theta - r_angb;
            r_angb2 <= r_angb;
        end
    end

    // Two sines by rotation: row 0 for a, row 1 for b
    logic signed [XW-1:0] w_rx [2][0:N];
    logic signed [XW-1:0] w_ry [2][0:N];
    logic signed [ZW-1:0] w_rz [2][0:N];

    for (genvar m = 0; m < 2; m++) begin : g_rot
        assign w_rx[m][0] = $signed(qslerp_pkg::CORDIC_GAIN_INV);
        assign w_ry[m][0] = '0;
        assign w_rz[m][0] = (m == 0) ? r_anga2 : r_angb2;
        for (genvar k = 0; k < N; k++) begin : g_cell
            qslerp_cordic_cell #(.STEP(k), .VECTOR(1'b0)) u_cell (
                .i_clk (i_clk),
                .i_en  (en),
                .i_x   (w_rx[m][k]),
                .i_y   (w_ry[m][k]),
                .i_z   (w_rz[m][k]),
                .o_x   (w_rx[m][k+1]),
                .o_y   (w_ry[m][k+1]),
                .o_z   (w_rz[m][k+1])
            );
        end
    end

    // Weights: |sin| << 30 / sin(theta), clamped to 2^34
    logic [30:0] w_drem [2][0:DIV_N];
    logic [34:0] w_ddl  [2][0:DIV_N];
    logic [34:0] w_dq   [2][0:DIV_N];
    logic [1:0]  w_dtag [2][0:DIV_N];

    for (genvar m = 0; m < 2; m++) begin : g_div
        logic        w_neg;
        logic [33:0] w_mag;
        logic        w_ovf;
        logic [30:0] r_rem0;
        logic [34:0] r_dl0;
        logic [1:0]  r_tag0;

        assign w_neg = w_ry[m][N][XW-1];
        assign w_mag = w_neg ? 34'(-w_ry[m][N]) : 34'(w_ry[m][N]);
        // a quotient of 2^35 or more saturates; flag it and skip the top bits
        assign w_ovf = ({2'b00, w_mag[33:5]} >= r_side[P_DPREP-1].s);

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_rem0 <= w_ovf ? 31'd0 : {2'b00, w_mag[33:5]};
                r_dl0  <= {w_mag[4:0], 30'd0};
                r_tag0 <= {w_neg, w_ovf};
            end
        end

        assign w_drem[m][0] = r_rem0;
        assign w_ddl[m][0]  = r_dl0;
        assign w_dq[m][0]   = '0;
        assign w_dtag[m][0] = r_tag0;

        for (genvar k = 0; k < DIV_N; k++) begin : g_cell
            qslerp_div_cell u_cell (
                .i_clk (i_clk),
                .i_en  (en),
                .i_den (r_side[P_DPREP+k].s),
                .i_rem (w_drem[m][k]),
                .i_dl  (w_ddl[m][k]),
                .i_q   (w_dq[m][k]),
                .i_tag (w_dtag[m][k]),
                .o_rem (w_drem[m][k+1]),
                .o_dl  (w_ddl[m][k+1]),
                .o_q   (w_dq[m][k+1]),
                .o_tag (w_dtag[m][k+1])
            );
        end
    end

    // Final weights; the linear blend reuses the same path with Q30 weights
    logic signed [35:0] r_w [2];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int m = 0; m < 2; m++) begin
                logic        big;
                logic [35:0] mag;
                logic        neg;
                logic [35:0] lw;
                big = w_dtag[m][DIV_N][0] || (w_dq[m][DIV_N] > qslerp_pkg::WEIGHT_LIMIT);
                mag = big ? {1'b0, qslerp_pkg::WEIGHT_LIMIT} : {1'b0, w_dq[m][DIV_N]};
                neg = w_dtag[m][DIV_N][1] ^ ((m == 1) && r_side[P_WGT-1].sflip);
                if (m == 0) begin
                    lw = 36'({qslerp_pkg::Q_ONE - {1'b0, r_side[P_WGT-1].t}, 15'd0});
                end else begin
                    lw = 36'({r_side[P_WGT-1].t, 15'd0});
                end
                if (r_side[P_WGT-1].lin) begin
                    r_w[m] <= ((m == 1) && r_side[P_WGT-1].sflip) ? -$signed(lw) : $signed(lw);
                end else begin
                    r_w[m] <= neg ? -$signed(mag) : $signed(mag);
                end
            end
        end
    end

    // a*wa + b*wb, round half up from Q45 to Q15, saturate
    logic signed [51:0] r_pa [4];
    logic signed [51:0] r_pb [4];
    qslerp_pkg::t_quat  r_res;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                logic signed [53:0] acc;
                r_pa[k] <= $signed(r_side[P_WGT].a[k]) * r_w[0];
                r_pb[k] <= $signed(r_side[P_WGT].b[k]) * r_w[1];
                acc = 54'(r_pa[k]) + 54'(r_pb[k]) + (54'sd1 <<< 29);
                r_res[k] <= qslerp_pkg::sat16(24'(acc >>> 30));
            end
        end
    end

    // Output queue: result register plus one skid entry
    logic              r_ov;
    logic              r_sv;
    qslerp_pkg::t_quat r_od;
    qslerp_pkg::t_quat r_sd;
    logic              w_push;
    logic              w_pop;

    assign en     = !r_sv;
    assign w_push = en && r_vld[P_LAST];
    assign w_pop  = r_ov && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_sv) begin
            // chain holds; drain the skid entry behind the transfer
            if (w_pop) begin
                r_sv <= 1'b0;
            end
        end else if (w_pop || !r_ov) begin
            r_ov <= w_push;
        end else if (w_push) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sv) begin
            if (w_pop) begin
                r_od <= r_sd;
            end
        end else if (w_pop || !r_ov) begin
            r_od <= r_res;
        end else begin
            r_sd <= r_res;
        end
    end

    assign o_in_ready  = en;
    assign o_out_valid = r_ov;
    assign o_r_w       = r_od[0];
    assign o_r_x       = r_od[1];
    assign o_r_y       = r_od[2];
    assign o_r_z       = r_od[3];
endmodule
